/* sv/sngr_pkg.sv */
// ----------------------------------------------------------------------------
// sngr_pkg
// Shared types and constants for the stereo noise gate with gain ramp.
// ----------------------------------------------------------------------------
package sngr_pkg;

    // Unity gain in Q1.15.
    localparam logic [15:0] Q_ONE        = 16'd32768;
    // Reset value of the ramp step, close to 0.005 in Q1.15.
    localparam logic [15:0] STEP_DEFAULT = 16'd164;

    // Width of the configuration port.
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 16;

    // Configuration register indexes.
    localparam logic [CFG_IDX_BITS-1:0] REG_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_WET_LEVEL = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_DRY_LEVEL = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_RAMP_STEP = 2'd3;

    // Current register contents, as written.
    typedef struct packed {
        logic [14:0] gate_threshold;
        logic [15:0] wet_level;
        logic [15:0] dry_level;
        logic [15:0] ramp_step;
    } cfg_t;

    // Limit a Q1.15 level to unity.
    function automatic logic [15:0] clamp_q(input logic [15:0] v);
        return (v > Q_ONE) ? Q_ONE : v;
    endfunction

endpackage

/* sv/sngr_mul.sv */
// ----------------------------------------------------------------------------
// sngr_mul
// Shared registered multiplier: signed operand times unsigned 32-bit operand.
// ----------------------------------------------------------------------------
module sngr_mul #(
    parameter int AW = 17
) (
    input  logic                 aclk,
    input  logic signed [AW-1:0] op_a,
    input  logic        [31:0]   op_b,
    output logic signed [AW+32:0] prod
);

    logic signed [32:0]    op_b_s;
    logic signed [AW+32:0] prod_reg;

    assign op_b_s = $signed({1'b0, op_b});

    // One product per cycle, registered before use.
    always_ff @(posedge aclk) begin
        prod_reg <= (AW+33)'(op_a) * (AW+33)'(op_b_s);
    end

    assign prod = prod_reg;

endmodule

/* sv/sngr_core.sv */
// ----------------------------------------------------------------------------
// sngr_core
// Sequencer that ramps each channel's gain and mixes it on the shared
// multiplier, one channel after the other.
// ----------------------------------------------------------------------------
module sngr_core #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  sngr_pkg::cfg_t                cfg,
    input  logic                          start,
    input  logic signed [SAMPLE_BITS-1:0] sample_left,
    input  logic signed [SAMPLE_BITS-1:0] sample_right,
    output logic                          idle,
    output logic                          done_valid,
    input  logic                          done_ack,
    output logic signed [SAMPLE_BITS-1:0] out_left,
    output logic signed [SAMPLE_BITS-1:0] out_right
);
    import sngr_pkg::*;

    localparam int SB = SAMPLE_BITS;
    localparam int AW = (SB > 17) ? SB : 17;
    localparam int PW = AW + 33;
    localparam int MW = (SB > 15) ? SB : 15;
    localparam logic signed [PW-1:0] SAT_HI = {{(PW-SB+1){1'b0}}, {(SB-1){1'b1}}};
    localparam logic signed [PW-1:0] SAT_LO = ~SAT_HI;
    localparam logic signed [PW-1:0] HALF   = {{(PW-30){1'b0}}, 1'b1, 29'd0};

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_RAMP  = 7'b0000010,
        S_WG    = 7'b0000100,
        S_COEF  = 7'b0001000,
        S_PROD  = 7'b0010000,
        S_ROUND = 7'b0100000,
        S_OUT   = 7'b1000000
    } state_t;

    state_t                  state_reg, state_next;
    logic                    ch_reg;
    logic signed [SB-1:0]    x_reg [2];
    logic        [15:0]      gain_reg [2];
    logic        [31:0]      coef_reg;
    logic signed [SB-1:0]    res_reg [2];

    logic signed [SB-1:0]    x_cur;
    logic        [SB-1:0]    mag;
    logic                    below;
    logic        [15:0]      step;
    logic        [16:0]      gain_up;
    logic        [15:0]      gain_new;
    logic signed [AW-1:0]    mul_a;
    logic        [31:0]      mul_b;
    logic signed [PW-1:0]    mul_p;
    logic signed [PW-1:0]    rounded;
    logic signed [PW-1:0]    shifted;
    logic signed [SB-1:0]    sat_val;

    assign x_cur = x_reg[ch_reg];

    // Gain ramp: magnitude compare against the threshold, then step and clamp.
    always_comb begin
        mag = x_cur[SB-1] ? (~x_cur + 1'b1) : x_cur;
        below = MW'(mag) < MW'(cfg.gate_threshold);
        step = clamp_q(cfg.ramp_step);
        gain_up = {1'b0, gain_reg[ch_reg]} + {1'b0, step};
        if (below) begin
            gain_new = (gain_reg[ch_reg] > step) ? (gain_reg[ch_reg] - step) : 16'd0;
        end else begin
            gain_new = (gain_up > {1'b0, Q_ONE}) ? Q_ONE : gain_up[15:0];
        end
    end

    // Multiplier operands: wet level times gain, then sample times coefficient.
    always_comb begin
        if (state_reg == S_PROD) begin
            mul_a = AW'(x_cur);
            mul_b = coef_reg;
        end else begin
            mul_a = $signed({{(AW-16){1'b0}}, clamp_q(cfg.wet_level)});
            mul_b = {16'd0, gain_reg[ch_reg]};
        end
    end

    sngr_mul #(.AW(AW)) u_mul (
        .aclk (aclk),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (mul_p)
    );

    // Round to nearest with ties upward, then saturate to the sample range.
    always_comb begin
        rounded = mul_p + HALF;
        shifted = rounded >>> 30;
        if (shifted > SAT_HI) begin
            sat_val = SAT_HI[SB-1:0];
        end else if (shifted < SAT_LO) begin
            sat_val = SAT_LO[SB-1:0];
        end else begin
            sat_val = shifted[SB-1:0];
        end
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (start) state_next = S_RAMP;
            S_RAMP:  state_next = S_WG;
            S_WG:    state_next = S_COEF;
            S_COEF:  state_next = S_PROD;
            S_PROD:  state_next = S_ROUND;
            S_ROUND: state_next = ch_reg ? S_OUT : S_RAMP;
            S_OUT:   if (done_ack) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // Control state and channel gains.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            ch_reg      <= 1'b0;
            gain_reg[0] <= Q_ONE;
            gain_reg[1] <= Q_ONE;
        end else begin
            state_reg <= state_next;
            if (state_reg == S_IDLE) begin
                ch_reg <= 1'b0;
            end else if (state_reg == S_ROUND) begin
                ch_reg <= ~ch_reg;
            end
            if (state_reg == S_RAMP) begin
                gain_reg[ch_reg] <= gain_new;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        if (state_reg == S_IDLE && start) begin
            x_reg[0] <= sample_left;
            x_reg[1] <= sample_right;
        end
        if (state_reg == S_COEF) begin
            coef_reg <= {1'b0, clamp_q(cfg.dry_level), 15'd0} + mul_p[31:0];
        end
        if (state_reg == S_ROUND) begin
            res_reg[ch_reg] <= sat_val;
        end
    end

    assign idle       = (state_reg == S_IDLE);
    assign done_valid = (state_reg == S_OUT);
    assign out_left   = res_reg[0];
    assign out_right  = res_reg[1];

endmodule

/* sv/stereo_noise_gate_ramped_unit.sv */
// ----------------------------------------------------------------------------
// stereo_noise_gate_ramped_unit
// Stereo noise gate with per-channel gain ramp and wet/dry mix.
// ----------------------------------------------------------------------------
// Usage:
//   The slave stream takes one stereo frame per item; the master stream
//   returns one mixed frame per item. Both carry the left sample in the low
//   bits of tdata and the right sample above it.
//   Settings go in through a write port (cfg_wr_en, cfg_index, cfg_wdata):
//   0 gate threshold, 1 wet level, 2 dry level, 3 ramp step. Write them only
//   while no item is in flight.
//   From acceptance to m_tvalid, the sequencer runs five steps per channel
//   (ramp, wet times gain, coefficient, sample times coefficient, round and
//   saturate) on one shared multiplier, then a hand-off step loads the frame
//   into the output register. The next item is taken the cycle after that
//   hand-off, so the block takes no new item while one is in flight.
//   The output register holds a finished frame while the receiver stalls,
//   and the block still accepts and processes the following item; it waits
//   at the hand-off until the register is free.
//   Reset (aresetn low, synchronous) restores both gains to unity, the
//   settings to their defaults, and empties the output register.
// ----------------------------------------------------------------------------
module stereo_noise_gate_ramped_unit #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Configuration writes.
    input  logic                                cfg_wr_en,
    input  logic [sngr_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [sngr_pkg::CFG_DATA_BITS-1:0]  cfg_wdata,
    // Input frames.
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // s_tdata: sample_left, sample_right, zero fill
    input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0]  s_tdata,
    // Output frames.
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // m_tdata: out_left, out_right, zero fill
    output logic [((2*SAMPLE_BITS+7)/8)*8-1:0]  m_tdata
);
    import sngr_pkg::*;

    localparam int SB = SAMPLE_BITS;
    localparam int DW = ((2*SB+7)/8)*8;

    cfg_t                 cfg_reg;
    logic                 core_idle;
    logic                 core_done;
    logic                 core_ack;
    logic signed [SB-1:0] core_left;
    logic signed [SB-1:0] core_right;
    logic                 m_valid_reg;
    logic [DW-1:0]        m_data_reg;

    // Configuration registers, masked to their widths.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.gate_threshold <= 15'd0;
            cfg_reg.wet_level      <= 16'd0;
            cfg_reg.dry_level      <= 16'd0;
            cfg_reg.ramp_step      <= STEP_DEFAULT;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_THRESHOLD: cfg_reg.gate_threshold <= cfg_wdata[14:0];
                REG_WET_LEVEL: cfg_reg.wet_level      <= cfg_wdata;
                REG_DRY_LEVEL: cfg_reg.dry_level      <= cfg_wdata;
                REG_RAMP_STEP: cfg_reg.ramp_step      <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign s_tready = core_idle;

    sngr_core #(.SAMPLE_BITS(SB)) u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg_reg),
        .start        (s_tvalid & s_tready),
        .sample_left  ($signed(s_tdata[SB-1:0])),
        .sample_right ($signed(s_tdata[2*SB-1:SB])),
        .idle         (core_idle),
        .done_valid   (core_done),
        .done_ack     (core_ack),
        .out_left     (core_left),
        .out_right    (core_right)
    );

    // Output register: loads a finished frame when empty or being drained.
    assign core_ack = core_done & (~m_valid_reg | m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (core_ack) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (core_ack) begin
            m_data_reg <= DW'({core_right, core_left});
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

/* sv/sngr_checker.sv */
// ----------------------------------------------------------------------------
// sngr_checker
// Port-level checks for the noise gate, bound to the top level.
// ----------------------------------------------------------------------------
module sngr_checker #(
    parameter int SAMPLE_BITS = 16
) (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_tvalid,
    input logic                                s_tready,
    input logic                                m_tvalid,
    input logic                                m_tready,
    input logic [((2*SAMPLE_BITS+7)/8)*8-1:0]  m_tdata
);

    // Reset empties the output register.
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("m_tvalid high after reset");

    // A stalled output item holds its data.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled output item changed");

    // An accepted item keeps the block busy in the next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input ready right after an accepted item");

    // A new result only comes out of a block that was busy.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result appeared from an idle block");

endmodule

bind stereo_noise_gate_ramped_unit sngr_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_sngr_checker (.*);
